// ----- src/sprite_row_blitter_macros.svh -----
// ----------------------------------------------------------------------------
// sprite_row_blitter_macros.svh
// Assertion shorthands used by the blitter checker.
// ----------------------------------------------------------------------------
`ifndef SPRITE_ROW_BLITTER_MACROS_SVH
`define SPRITE_ROW_BLITTER_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define SRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define SRB_ASSERT_NEVER(lbl, expr, msg) \
  `SRB_ASSERT(lbl, !(expr), msg)

`endif

// ----- src/srb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_pkg
// Types and constants of the sprite row blitter.
// ----------------------------------------------------------------------------
package srb_pkg;

  localparam int ADDR_W     = 19;  // linear frame-buffer address
  localparam int XY_W       = 13;  // screen coordinates incl. 2x overhang
  localparam int SW_W       = 6;   // sprite_width register
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_SIZE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAINT_COLOR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_MODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BG    = 3'd4;

  typedef enum logic [1:0] {
    ACT_PAINT = 2'd0,
    ACT_COPY  = 2'd1,
    ACT_LEAVE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADDR,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic [31:0] row_bits;
    logic [4:0]  row_number;
    logic [9:0]  origin_x;
    logic [8:0]  origin_y;
    logic        final_row;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pixel_address;
    logic [1:0]        action;
    logic              off_screen;
    logic              last_of_row;
    logic              last_of_sprite;
  } result_t;

  typedef struct packed {
    logic load_item;
    logic load_addr;
    logic step;
  } col_ctrl_t;

endpackage

// ----- src/srb_setup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_setup
// Row origin: screen row of the item and linear address of its first column.
// ----------------------------------------------------------------------------
module srb_setup #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic                       dbl_i,
  input  srb_pkg::item_t             item_i,
  output logic [srb_pkg::ADDR_W-1:0] base_o,
  output logic                       y_off_o
);
  import srb_pkg::*;

  localparam int PW = 2 * XY_W;

  logic [XY_W-1:0] y_q, y_d;
  logic [XY_W-1:0] x0_q;
  logic            ext_q;
  logic [XY_W-1:0] row_ext;
  logic [PW-1:0]   prod;

  assign row_ext = XY_W'(item_i.row_number);
  assign y_d     = XY_W'(item_i.origin_y) + (dbl_i ? (row_ext << 1) : row_ext);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      y_q   <= y_d;
      x0_q  <= XY_W'(item_i.origin_x);
      ext_q <= dbl_i;
    end
  end

  assign prod    = PW'(y_q) * PW'(SCREEN_WIDTH);
  assign base_o  = ADDR_W'(prod + PW'(x0_q));
  assign y_off_o = (y_q + XY_W'(ext_q)) >= XY_W'(SCREEN_HEIGHT);

endmodule

// ----- src/srb_column.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_column
// Column serializer: shifts the row word out MSB first, one column per cycle,
// stepping x and the linear address and forming each result.
// ----------------------------------------------------------------------------
module srb_column #(
  parameter int SCREEN_WIDTH     = 640,
  parameter int MAX_SPRITE_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  srb_pkg::col_ctrl_t         ctrl_i,
  input  srb_pkg::item_t             item_i,
  input  logic [srb_pkg::SW_W-1:0]   width_i,
  input  logic                       dbl_i,
  input  logic                       erase_i,
  input  logic                       tib_i,
  input  logic [srb_pkg::ADDR_W-1:0] base_i,
  input  logic                       y_off_i,
  output logic                       last_o,
  output logic                       res_valid_o,
  output srb_pkg::result_t           result_o
);
  import srb_pkg::*;

  localparam int CNT_W = $clog2(MAX_SPRITE_WIDTH);

  logic [MAX_SPRITE_WIDTH-1:0] bits_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        fin_q;
  logic [XY_W-1:0]             x_q;
  logic [ADDR_W-1:0]           addr_q;
  logic                        yoff_q;
  logic                        vld_q;
  result_t                     res_q, res_d;
  logic [SW_W-1:0]             align;
  logic [1:0]                  scale;
  logic                        off, set;

  assign align = SW_W'(MAX_SPRITE_WIDTH) - width_i;
  assign scale = dbl_i ? 2'd2 : 2'd1;
  assign last_o = (cnt_q == '0);

  always_comb begin
    off = yoff_q || ((x_q + XY_W'(dbl_i)) >= XY_W'(SCREEN_WIDTH));
    set = bits_q[MAX_SPRITE_WIDTH-1] && !erase_i;
    res_d = '0;
    res_d.off_screen     = off;
    res_d.last_of_row    = last_o;
    res_d.last_of_sprite = last_o && fin_q;
    if (off) begin
      res_d.action = ACT_LEAVE;
    end else begin
      res_d.pixel_address = addr_q;
      if (set) begin
        res_d.action = ACT_PAINT;
      end else if (tib_i) begin
        res_d.action = ACT_LEAVE;
      end else begin
        res_d.action = ACT_COPY;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_item) begin
      // column 0 lands on the MSB
      bits_q <= item_i.row_bits[MAX_SPRITE_WIDTH-1:0] << align;
      cnt_q  <= CNT_W'(width_i - SW_W'(1));
      fin_q  <= item_i.final_row;
      x_q    <= XY_W'(item_i.origin_x);
    end else if (ctrl_i.step) begin
      bits_q <= {bits_q[MAX_SPRITE_WIDTH-2:0], 1'b0};
      cnt_q  <= cnt_q - CNT_W'(1);
      x_q    <= x_q + XY_W'(scale);
      addr_q <= addr_q + ADDR_W'(scale);
    end
    if (ctrl_i.load_addr) begin
      addr_q <= base_i;
      yoff_q <= y_off_i;
    end
    if (ctrl_i.step) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= ctrl_i.step;
    end
  end

  assign res_valid_o = vld_q;
  assign result_o    = res_q;

endmodule

// ----- src/sprite_row_blitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_row_blitter
// One-bit sprite row blitter with optional 2x2 pixel doubling.
// ----------------------------------------------------------------------------
// Usage:
//   Drive item_i and raise start; the item is taken at an edge where start is
//   high and busy is low. For each of the w used columns (w = sprite_width,
//   capped at MAX_SPRITE_WIDTH) one result is shown on result_o for a single
//   cycle with result_valid_o high, column 0 first.
//   After the accepting edge, ST_ADDR computes the row's base address (one
//   multiply by the screen width); then ST_RUN shifts the column register,
//   which emits one registered result per cycle. Busy drops in the cycle
//   that shows the last result, so the next item can be taken there.
//   A row with w = 0 gives no results; it goes from ST_ADDR back to idle.
//   The receiver cannot stall: results are not held.
//   Configuration (cfg_we_i/cfg_idx_i/cfg_data_i) is to be written only while
//   idle; the block does not enforce this. paint_color is not stored here.
//   Reset restores register defaults (width 16, doubling on) and idles.
// ----------------------------------------------------------------------------
module sprite_row_blitter #(
  parameter int SCREEN_WIDTH     = 640,
  parameter int SCREEN_HEIGHT    = 480,
  parameter int MAX_SPRITE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  srb_pkg::item_t                 item_i,
  input  logic                           cfg_we_i,
  input  logic [srb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [srb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           result_valid_o,
  output srb_pkg::result_t               result_o
);
  import srb_pkg::*;

  localparam logic [SW_W-1:0] MAX_W = SW_W'(MAX_SPRITE_WIDTH);

  logic [SW_W-1:0]   sw_q;
  logic              dbl_q, erase_q, tib_q;
  logic              zero_q;
  state_e            state_q, state_d;
  col_ctrl_t         ctrl;
  logic [SW_W-1:0]   width;
  logic              accept;
  logic [ADDR_W-1:0] base;
  logic              y_off;
  logic              last;

  assign width  = (sw_q > MAX_W) ? MAX_W : sw_q;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q    <= SW_W'(16);
      dbl_q   <= 1'b1;
      erase_q <= 1'b0;
      tib_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SPRITE_WIDTH: sw_q    <= cfg_data_i[SW_W-1:0];
        CFG_DOUBLE_SIZE:  dbl_q   <= cfg_data_i[0];
        CFG_ERASE_MODE:   erase_q <= cfg_data_i[0];
        CFG_TARGET_BG:    tib_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        zero_q <= (width == '0);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl    = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctrl.load_item = 1'b1;
          state_d        = ST_ADDR;
        end
      end
      ST_ADDR: begin
        ctrl.load_addr = 1'b1;
        state_d        = zero_q ? ST_IDLE : ST_RUN;
      end
      ST_RUN: begin
        ctrl.step = 1'b1;
        if (last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  srb_setup #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_setup (
    .clk_i  (clk_i),
    .load_i (ctrl.load_item),
    .dbl_i  (dbl_q),
    .item_i (item_i),
    .base_o (base),
    .y_off_o(y_off)
  );

  srb_column #(
    .SCREEN_WIDTH    (SCREEN_WIDTH),
    .MAX_SPRITE_WIDTH(MAX_SPRITE_WIDTH)
  ) u_column (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .item_i     (item_i),
    .width_i    (width),
    .dbl_i      (dbl_q),
    .erase_i    (erase_q),
    .tib_i      (tib_q),
    .base_i     (base),
    .y_off_i    (y_off),
    .last_o     (last),
    .res_valid_o(result_valid_o),
    .result_o   (result_o)
  );

endmodule

// ----- src/srb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_checker
// Port-level checks of the sprite row blitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "sprite_row_blitter_macros.svh"

module srb_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             result_valid_o,
  input srb_pkg::result_t result_o
);
  import srb_pkg::*;

  `SRB_ASSERT(a_result_follows_busy, result_valid_o |-> $past(busy), "result without an item")
  `SRB_ASSERT(a_accept_gap, (start && !busy) |=> !result_valid_o, "result right after accept")
  `SRB_ASSERT(a_row_end_frees, (result_valid_o && result_o.last_of_row) |-> !busy, "busy after row end")
  `SRB_ASSERT_NEVER(a_off_leaves, result_valid_o && result_o.off_screen && (result_o.action != ACT_LEAVE || result_o.pixel_address != '0), "off-screen result not suppressed")
  `SRB_ASSERT_NEVER(a_sprite_end_row, result_valid_o && result_o.last_of_sprite && !result_o.last_of_row, "sprite end not on row end")

endmodule

bind sprite_row_blitter srb_checker u_srb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_o(result_valid_o),
  .result_o      (result_o)
);
